// ===== hdl/bcct_pkg.sv =====
package bcct_pkg;

    // Default sizes of the shape table and of a coordinate.
    localparam int SLOTS_DEF      = 16;
    localparam int COORD_BITS_DEF = 16;

    // Width of the slot field on the item and of the partner field on the result.
    localparam int SLOT_W = 4;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;

    // Shape kind codes; every other code has no volume.
    localparam logic [1:0] KIND_BOX    = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic a_load;
        logic issue;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;
        logic pipe_empty;
        logic out_free;
        logic usable;
    } dp_status_t;

    // A slot takes part in collisions when it is active and has a volume.
    function automatic logic usable_flags(input logic [2:0] flags);
        return flags[0] && ((flags[2:1] == KIND_BOX) || (flags[2:1] == KIND_CIRCLE));
    endfunction

endpackage

// ===== hdl/bcct_item_if.sv =====
interface bcct_item_if #(
    parameter int COORD_BITS = bcct_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bcct_pkg::SLOT_W-1:0]   slot;
    logic                          active;
    logic [1:0]                    kind;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-2:0]         size_w;
    logic [COORD_BITS-2:0]         size_h;

    modport source (
        output valid, func, slot, active, kind, pos_x, pos_y, size_w, size_h,
        input  ready
    );

    modport sink (
        input  valid, func, slot, active, kind, pos_x, pos_y, size_w, size_h,
        output ready
    );
endinterface

// ===== hdl/bcct_result_if.sv =====
interface bcct_result_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [bcct_pkg::SLOT_W-1:0] partner;
    logic                        last;

    modport source (
        output valid, hit, partner, last,
        input  ready
    );

    modport sink (
        input  valid, hit, partner, last,
        output ready
    );
endinterface

// ===== hdl/bcct_datapath.sv =====
module bcct_datapath #(
    parameter int SLOTS      = bcct_pkg::SLOTS_DEF,
    parameter int COORD_BITS = bcct_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcct_pkg::dp_cmd_t           cmd,
    input  logic [$clog2(SLOTS)-1:0]    addr,
    output bcct_pkg::dp_status_t        status,
    input  logic                        active,
    input  logic [1:0]                  kind,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic [COORD_BITS-2:0]       size_w,
    input  logic [COORD_BITS-2:0]       size_h,
    bcct_result_if.source               rsp
);

    localparam int C     = COORD_BITS;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int REC_W = 4 * C - 2;
    localparam logic [IDX_W:0] SLOTS_V = (IDX_W + 1)'(SLOTS);

    typedef enum logic [1:0] {
        PM_NONE,
        PM_BB,
        PM_BC,
        PM_CC
    } pair_mode_t;

    // Sign-extend a coordinate by one bit.
    function automatic logic signed [C:0] sx(input logic [C-1:0] v);
        return $signed({v[C-1], v});
    endfunction

    // Zero-extend a size to the extended coordinate width.
    function automatic logic signed [C:0] uw(input logic [C-2:0] w);
        return $signed({2'b00, w});
    endfunction

    // Distance from p to the closed interval [lo, hi]; always below 2^C.
    function automatic logic [C-1:0] clamp_dist(
        input logic signed [C:0] p,
        input logic signed [C:0] lo,
        input logic signed [C:0] hi
    );
        logic signed [C:0] d_lo;
        logic signed [C:0] d_hi;
        logic [C-1:0]      res;
        d_lo = lo - p;
        d_hi = p - hi;
        if (p < lo)
        begin
            res = d_lo[C-1:0];
        end
        else if (p > hi)
        begin
            res = d_hi[C-1:0];
        end
        else
        begin
            res = '0;
        end
        return res;
    endfunction

    // Magnitude of a coordinate difference; always below 2^C.
    function automatic logic [C-1:0] abs_diff(input logic signed [C:0] d);
        logic signed [C:0] n;
        n = -d;
        return d[C] ? n[C-1:0] : d[C-1:0];
    endfunction

    // Shape storage: flags are cleared at reset, records are not.
    logic [2:0]       flags_reg [SLOTS];
    logic [REC_W-1:0] rec_mem   [SLOTS];
    logic [REC_W-1:0] rd_data_reg;
    logic [2:0]       flag_rd;

    // Record of the checked slot.
    logic [C-1:0] ax_reg, ay_reg;
    logic [C-2:0] aw_reg, ah_reg;
    logic [1:0]   kind_a_reg;

    // Pipeline stages.
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0] j1_reg, j2_reg, j3_reg, j4_reg;
    logic [1:0]       kind_b1_reg;
    pair_mode_t       mode2_reg, mode3_reg, mode4_reg;
    logic             bb2_reg, bb3_reg, bb4_reg;
    logic signed [C:0] px2_reg, py2_reg, lox2_reg, hix2_reg, loy2_reg, hiy2_reg;
    logic [C-1:0]     rad2_reg, rad3_reg;
    logic [C-1:0]     ux3_reg, uy3_reg;
    logic [2*C-1:0]   sqx4_reg, sqy4_reg, sqr4_reg;

    // Result holding and output register.
    logic                        pend_valid_reg;
    logic [IDX_W-1:0]            pend_j_reg;
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [bcct_pkg::SLOT_W-1:0] out_partner_reg;
    logic                        out_last_reg;

    logic advance;
    logic out_free;
    logic pipe_empty;
    logic s4_hit;
    logic push_mid;
    logic push_final;

    // Stage one combinational signals.
    logic [C-1:0]     bx, by;
    logic [C-2:0]     bw, bh;
    pair_mode_t       mode1;
    logic             swap1;
    logic             bb1;
    logic [C-1:0]     box_x, box_y, cir_x, cir_y;
    logic [C-2:0]     box_w, box_h, cir_r;
    logic signed [C:0] px1, py1, lox1, hix1, loy1, hiy1;
    logic [C-1:0]     rad1;

    logic [C-1:0]     ux2, uy2;
    logic [2*C:0]     dist4;
    logic             pair_hit4;

    // Flags read port, zero outside the table.
    assign flag_rd = ({1'b0, addr} < SLOTS_V) ? flags_reg[addr] : 3'b000;

    // Flag table with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '{default: 3'b000};
        end
        else if (cmd.wr_en)
        begin
            flags_reg[addr] <= {kind, active};
        end
    end

    // Position and size memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            rec_mem[addr] <= {size_h, size_w, pos_y, pos_x};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= rec_mem[addr];
        end
    end

    // Latch the checked slot.
    always_ff @(posedge clk)
    begin
        if (cmd.a_load)
        begin
            ax_reg     <= rd_data_reg[C-1:0];
            ay_reg     <= rd_data_reg[2*C-1:C];
            aw_reg     <= rd_data_reg[3*C-2:2*C];
            ah_reg     <= rd_data_reg[4*C-3:3*C-1];
            kind_a_reg <= flag_rd[2:1];
        end
    end

    // Stage one: box overlap, and edges or differences for the round tests.
    always_comb
    begin
        bx = rd_data_reg[C-1:0];
        by = rd_data_reg[2*C-1:C];
        bw = rd_data_reg[3*C-2:2*C];
        bh = rd_data_reg[4*C-3:3*C-1];

        if ((kind_a_reg == bcct_pkg::KIND_BOX) && (kind_b1_reg == bcct_pkg::KIND_BOX))
        begin
            mode1 = PM_BB;
        end
        else if ((kind_a_reg == bcct_pkg::KIND_CIRCLE)
                 && (kind_b1_reg == bcct_pkg::KIND_CIRCLE))
        begin
            mode1 = PM_CC;
        end
        else if (((kind_a_reg == bcct_pkg::KIND_BOX) && (kind_b1_reg == bcct_pkg::KIND_CIRCLE))
                 || ((kind_a_reg == bcct_pkg::KIND_CIRCLE)
                     && (kind_b1_reg == bcct_pkg::KIND_BOX)))
        begin
            mode1 = PM_BC;
        end
        else
        begin
            mode1 = PM_NONE;
        end

        bb1 = (sx(ax_reg) < sx(bx) + uw(bw)) && (sx(bx) < sx(ax_reg) + uw(aw_reg))
              && (sx(ay_reg) < sx(by) + uw(bh)) && (sx(by) < sx(ay_reg) + uw(ah_reg));

        // The box is the checked slot unless that one is the circle.
        swap1 = (kind_a_reg == bcct_pkg::KIND_CIRCLE);
        box_x = swap1 ? bx : ax_reg;
        box_y = swap1 ? by : ay_reg;
        box_w = swap1 ? bw : aw_reg;
        box_h = swap1 ? bh : ah_reg;
        cir_x = swap1 ? ax_reg : bx;
        cir_y = swap1 ? ay_reg : by;
        cir_r = swap1 ? aw_reg : bw;

        lox1 = sx(box_x);
        hix1 = sx(box_x) + uw(box_w);
        loy1 = sx(box_y);
        hiy1 = sx(box_y) + uw(box_h);

        if (mode1 == PM_CC)
        begin
            px1  = sx(bx) - sx(ax_reg);
            py1  = sx(by) - sx(ay_reg);
            rad1 = {1'b0, aw_reg} + {1'b0, bw};
        end
        else
        begin
            px1  = sx(cir_x);
            py1  = sx(cir_y);
            rad1 = {1'b0, cir_r};
        end
    end

    // Stage two: per-axis distances.
    always_comb
    begin
        if (mode2_reg == PM_CC)
        begin
            ux2 = abs_diff(px2_reg);
            uy2 = abs_diff(py2_reg);
        end
        else
        begin
            ux2 = clamp_dist(px2_reg, lox2_reg, hix2_reg);
            uy2 = clamp_dist(py2_reg, loy2_reg, hiy2_reg);
        end
    end

    // Stage four: sum of squares against the squared radius, or the box overlap for two boxes.
    always_comb
    begin
        dist4 = {1'b0, sqx4_reg} + {1'b0, sqy4_reg};
        case (mode4_reg)
            PM_BB:   pair_hit4 = bb4_reg;
            PM_BC,
            PM_CC:   pair_hit4 = (dist4 <= {1'b0, sqr4_reg});
            default: pair_hit4 = 1'b0;
        endcase
    end

    // Stall the pipeline only when a hit must leave but the output is full.
    assign out_free   = !out_valid_reg || rsp.ready;
    assign s4_hit     = v4_reg && pair_hit4;
    assign advance    = !(s4_hit && pend_valid_reg && !out_free);
    assign push_mid   = advance && s4_hit && pend_valid_reg;
    assign push_final = cmd.finish && out_free;
    assign pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= cmd.issue && bcct_pkg::usable_flags(flag_rd);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            j1_reg      <= addr;
            kind_b1_reg <= flag_rd[2:1];

            j2_reg    <= j1_reg;
            mode2_reg <= mode1;
            bb2_reg   <= bb1;
            px2_reg   <= px1;
            py2_reg   <= py1;
            lox2_reg  <= lox1;
            hix2_reg  <= hix1;
            loy2_reg  <= loy1;
            hiy2_reg  <= hiy1;
            rad2_reg  <= rad1;

            j3_reg    <= j2_reg;
            mode3_reg <= mode2_reg;
            bb3_reg   <= bb2_reg;
            ux3_reg   <= ux2;
            uy3_reg   <= uy2;
            rad3_reg  <= rad2_reg;

            j4_reg    <= j3_reg;
            mode4_reg <= mode3_reg;
            bb4_reg   <= bb3_reg;
            sqx4_reg  <= ux3_reg * ux3_reg;
            sqy4_reg  <= uy3_reg * uy3_reg;
            sqr4_reg  <= rad3_reg * rad3_reg;
        end
    end

    // One hit is held back so that the final one can carry the last mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (advance && s4_hit)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (push_final)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s4_hit)
        begin
            pend_j_reg <= j4_reg;
        end
    end

    // Output register: valid is control, the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_mid || push_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_mid)
        begin
            out_hit_reg     <= 1'b1;
            out_partner_reg <= bcct_pkg::SLOT_W'(pend_j_reg);
            out_last_reg    <= 1'b0;
        end
        else if (push_final)
        begin
            out_hit_reg     <= pend_valid_reg;
            out_partner_reg <= pend_valid_reg ? bcct_pkg::SLOT_W'(pend_j_reg) : '0;
            out_last_reg    <= 1'b1;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.hit     = out_hit_reg;
    assign rsp.partner = out_partner_reg;
    assign rsp.last    = out_last_reg;

    assign status.advance    = advance;
    assign status.pipe_empty = pipe_empty;
    assign status.out_free   = out_free;
    assign status.usable     = bcct_pkg::usable_flags(flag_rd);

`ifndef SYNTHESIS
    // A no-hit result is only ever the final result of a check.
    a_nohit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> out_last_reg)
        else $error("no-hit result without last mark");

    // The final result is only produced after the pair pipeline has drained.
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> pipe_empty)
        else $error("final result while pairs are still in flight");

    // A stalled hit stays in the last stage with its partner index.
    a_stall_holds_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !advance) |=> (v4_reg && $stable(j4_reg)))
        else $error("stalled hit lost from the last stage");
`endif

endmodule

// ===== hdl/bcct_ctrl.sv =====
module bcct_ctrl #(
    parameter int SLOTS = bcct_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_func,
    input  logic [bcct_pkg::SLOT_W-1:0] req_slot,
    output logic                        req_ready,
    output bcct_pkg::dp_cmd_t           cmd,
    output logic [$clog2(SLOTS)-1:0]    addr,
    input  bcct_pkg::dp_status_t        status
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int RW    = ((IDX_W > bcct_pkg::SLOT_W) ? IDX_W : bcct_pkg::SLOT_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    bcct_pkg::ctl_state_t state_reg, state_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic                 in_range;

    assign in_range = (RW'(req_slot) < RW'(SLOTS));

    // State and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcct_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        addr       = j_reg;
        req_ready  = 1'b0;

        case (state_reg)
            bcct_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                addr      = IDX_W'(req_slot);
                if (req_valid)
                begin
                    if (req_func == bcct_pkg::FUNC_WRITE)
                    begin
                        cmd.wr_en = in_range;
                    end
                    else
                    begin
                        // Read the checked slot's record right away.
                        cmd.rd_en = 1'b1;
                        i_next    = IDX_W'(req_slot);
                        if (in_range && status.usable)
                        begin
                            state_next = bcct_pkg::ST_LOAD;
                        end
                        else
                        begin
                            state_next = bcct_pkg::ST_FINISH;
                        end
                    end
                end
            end

            bcct_pkg::ST_LOAD:
            begin
                addr       = i_reg;
                cmd.a_load = 1'b1;
                if (i_reg == LAST_IDX)
                begin
                    state_next = bcct_pkg::ST_FINISH;
                end
                else
                begin
                    j_next     = i_reg + 1'b1;
                    state_next = bcct_pkg::ST_WALK;
                end
            end

            bcct_pkg::ST_WALK:
            begin
                // One partner slot enters the pair pipeline per cycle while the pipeline advances.
                cmd.issue = 1'b1;
                cmd.rd_en = status.advance;
                if (status.advance)
                begin
                    if (j_reg == LAST_IDX)
                    begin
                        state_next = bcct_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            bcct_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = bcct_pkg::ST_FINISH;
                end
            end

            bcct_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                if (status.out_free)
                begin
                    state_next = bcct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bcct_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Partners are always above the checked slot.
    a_walk_above: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcct_pkg::ST_WALK) |-> (j_reg > i_reg))
        else $error("partner index not above checked slot");

    // The checked record was read in the cycle before it is latched.
    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcct_pkg::ST_LOAD) |-> $past(cmd.rd_en))
        else $error("checked slot latched without a read");

    // A drained walk always ends in the final result.
    a_drain_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcct_pkg::ST_DRAIN && status.pipe_empty)
        |=> (state_reg == bcct_pkg::ST_FINISH))
        else $error("drain did not move to finish");
`endif

endmodule

// ===== hdl/box_circle_collision_table.sv =====
// Write beat: accepted when idle; it gives no result.
// Check beat on usable slot i < SLOTS-1: the record of i is read and latched, the partner slots
// above i are issued one per cycle while the pipeline advances and pass four pair stages, and
// after the drain the final result goes out; the next beat is taken once idle again.
// A check on the top slot skips the walk, one on an unusable slot also the latch; stalls add.
// Reset clears the flag table at once; positions and sizes have no reset or clearing pass.
module box_circle_collision_table #(
    parameter int SLOTS      = bcct_pkg::SLOTS_DEF,
    parameter int COORD_BITS = bcct_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bcct_item_if.sink     req,
    bcct_result_if.source rsp
);

    localparam int IDX_W = $clog2(SLOTS);

    bcct_pkg::dp_cmd_t    cmd;
    bcct_pkg::dp_status_t status;
    logic [IDX_W-1:0]     addr;

    // Sequencer for the pair walk.
    bcct_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_slot  (req.slot),
        .req_ready (req.ready),
        .cmd       (cmd),
        .addr      (addr),
        .status    (status)
    );

    // Shape storage, pair tests and result register.
    bcct_datapath #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .addr   (addr),
        .status (status),
        .active (req.active),
        .kind   (req.kind),
        .pos_x  (req.pos_x),
        .pos_y  (req.pos_y),
        .size_w (req.size_w),
        .size_h (req.size_h),
        .rsp    (rsp)
    );

endmodule
